FILE: rtl/gds_pkg.sv
// shared types, constants and helpers of the gesture decision smoother
package gds_pkg;

    localparam int MAX_GESTURES = 8;
    localparam int FRAC_BITS    = 10;
    localparam int CONF_W       = FRAC_BITS + 1;
    localparam int IDX_W        = (MAX_GESTURES > 1) ? $clog2(MAX_GESTURES) : 1;
    localparam int CNT_W        = 4;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [CONF_W-1:0] ONE_Q = CONF_W'(1 << FRAC_BITS);
    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_GESTURES);

    localparam logic [CNT_W-1:0]  RST_COUNT = CNT_W'(5);
    localparam logic [CONF_W-1:0] RST_STEP  = CONF_W'(102);
    localparam logic [CONF_W-1:0] RST_ACC   = CONF_W'(819);
    localparam logic [CONF_W-1:0] RST_HOLD  = CONF_W'(512);

    typedef enum logic [1:0] {
        REG_COUNT,
        REG_STEP,
        REG_ACC,
        REG_HOLD
    } reg_idx_t;

    typedef enum logic [1:0] {
        EV_SAME,
        EV_NEW,
        EV_END
    } ev_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LIKE,
        S_UPDATE,
        S_CAND,
        S_DECIDE
    } state_t;

    typedef enum logic {
        OP_CMP,
        OP_UPDATE
    } alu_op_t;

    // effective configuration, already limited to its legal range
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CONF_W-1:0] step;
        logic [CONF_W-1:0] acc;
        logic [CONF_W-1:0] hold;
    } cfg_t;

    typedef struct packed {
        alu_op_t           op;
        logic [CONF_W-1:0] a;
        logic [CONF_W-1:0] b;
        logic [CONF_W-1:0] thr;
        logic [CONF_W-1:0] step;
        logic              winner;
    } alu_req_t;

    typedef struct packed {
        logic              greater;
        logic [CONF_W-1:0] value;
    } alu_res_t;

    function automatic logic [CONF_W-1:0] sat_one(input logic [CONF_W-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

endpackage

FILE: rtl/gds_cfg.sv
// apb register file holding the smoother configuration
module gds_cfg import gds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [CNT_W-1:0]  count_reg;
    logic [CONF_W-1:0] step_reg;
    logic [CONF_W-1:0] acc_reg;
    logic [CONF_W-1:0] hold_reg;
    reg_idx_t          sel;
    logic              wr_en;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= RST_COUNT;
            step_reg  <= RST_STEP;
            acc_reg   <= RST_ACC;
            hold_reg  <= RST_HOLD;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_COUNT: count_reg <= pwdata[CNT_W-1:0];
                REG_STEP:  step_reg  <= pwdata[CONF_W-1:0];
                REG_ACC:   acc_reg   <= pwdata[CONF_W-1:0];
                REG_HOLD:  hold_reg  <= pwdata[CONF_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_COUNT: prdata = DATA_W'(count_reg);
            REG_STEP:  prdata = DATA_W'(step_reg);
            REG_ACC:   prdata = DATA_W'(acc_reg);
            REG_HOLD:  prdata = DATA_W'(hold_reg);
            default:   prdata = '0;
        endcase
    end

    // zero count means one gesture, large counts stop at the library size
    always_comb
    begin
        if (count_reg == '0)
            cfg.count = CNT_W'(1);
        else if (count_reg > MAX_CNT)
            cfg.count = MAX_CNT;
        else
            cfg.count = count_reg;
        cfg.step = sat_one(step_reg);
        cfg.acc  = sat_one(acc_reg);
        cfg.hold = sat_one(hold_reg);
    end

endmodule

FILE: rtl/gds_alu.sv
// shared compare and confidence update unit
module gds_alu import gds_pkg::*;
(
    input  alu_req_t req,
    output alu_res_t res
);

    logic [CONF_W:0]   sum;
    logic [CONF_W:0]   lifted;

    always_comb
    begin
        sum    = {1'b0, req.a} + {1'b0, req.step};
        lifted = ({1'b0, req.b} > sum) ? {1'b0, req.b} : sum;
        res.greater = (req.a > req.b) && (req.a > req.thr);
        case (req.op)
            OP_UPDATE:
            begin
                if (req.winner)
                    res.value = (lifted > {1'b0, ONE_Q}) ? ONE_Q : lifted[CONF_W-1:0];
                else
                    res.value = (req.a > req.step) ? (req.a - req.step) : '0;
            end
            default: res.value = req.a;
        endcase
    end

endmodule

FILE: rtl/gesture_decision_smoother_core.sv
// top level of the gesture decision smoother: sequencer, state and result register
// sequencing: a clear item is handled in the idle state, a likelihood item passes through S_LIKE,
// the item that ends a frame then walks S_UPDATE and S_CAND over the n active gestures and ends in S_DECIDE,
// which waits for the result register to drain
// throughput: one item at a time, set by the single shared update unit walking n entries twice
// reset: asynchronous, clears confidences, held gesture, frame state and registers to defaults
module gesture_decision_smoother_core import gds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input item channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [CONF_W-1:0] likelihood,
    // result item channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        event_res,
    output logic              best_valid,
    output logic [IDX_W-1:0]  best_index,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg;
    alu_req_t alu_req;
    alu_res_t alu_res;

    // sequencer and per-gesture state
    state_t            state_reg,     state_next;
    logic [CONF_W-1:0] conf_reg       [MAX_GESTURES];
    logic [CONF_W-1:0] conf_next      [MAX_GESTURES];
    logic [IDX_W-1:0]  idx_reg,       idx_next;
    logic [CONF_W-1:0] lk_reg,        lk_next;

    // frame accumulation
    logic [IDX_W-1:0]  pos_reg,       pos_next;
    logic [CONF_W-1:0] frame_max_reg, frame_max_next;
    logic [IDX_W-1:0]  winner_reg,    winner_next;
    logic              found_reg,     found_next;

    // candidate search
    logic [CONF_W-1:0] cand_max_reg,  cand_max_next;
    logic [IDX_W-1:0]  cand_idx_reg,  cand_idx_next;
    logic              cand_found_reg, cand_found_next;

    // held decision
    logic [IDX_W-1:0]  held_idx_reg,  held_idx_next;
    logic              held_valid_reg, held_valid_next;

    // result register, parts the sequencer from the downstream stall
    logic              out_valid_reg, out_valid_next;
    ev_t               out_ev_reg,    out_ev_next;
    logic              out_bv_reg,    out_bv_next;
    logic [IDX_W-1:0]  out_bi_reg,    out_bi_next;

    logic              last_item;
    logic              last_idx;

    gds_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gds_alu u_alu
    (
        .req (alu_req),
        .res (alu_res)
    );

    // the frame ends at the item that reaches or passes the last position
    assign last_item = (CNT_W'(pos_reg) + CNT_W'(1)) >= cfg.count;
    assign last_idx  = (CNT_W'(idx_reg) + CNT_W'(1)) >= cfg.count;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign event_res  = out_ev_reg;
    assign best_valid = out_bv_reg;
    assign best_index = out_bi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            for (int i = 0; i < MAX_GESTURES; i++)
            begin
                conf_reg[i] <= '0;
            end
            idx_reg        <= '0;
            pos_reg        <= '0;
            frame_max_reg  <= '0;
            winner_reg     <= '0;
            found_reg      <= 1'b0;
            cand_max_reg   <= '0;
            cand_idx_reg   <= '0;
            cand_found_reg <= 1'b0;
            held_idx_reg   <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            conf_reg       <= conf_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            frame_max_reg  <= frame_max_next;
            winner_reg     <= winner_next;
            found_reg      <= found_next;
            cand_max_reg   <= cand_max_next;
            cand_idx_reg   <= cand_idx_next;
            cand_found_reg <= cand_found_next;
            held_idx_reg   <= held_idx_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        lk_reg     <= lk_next;
        out_ev_reg <= out_ev_next;
        out_bv_reg <= out_bv_next;
        out_bi_reg <= out_bi_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        conf_next       = conf_reg;
        idx_next        = idx_reg;
        lk_next         = lk_reg;
        pos_next        = pos_reg;
        frame_max_next  = frame_max_reg;
        winner_next     = winner_reg;
        found_next      = found_reg;
        cand_max_next   = cand_max_reg;
        cand_idx_next   = cand_idx_reg;
        cand_found_next = cand_found_reg;
        held_idx_next   = held_idx_reg;
        held_valid_next = held_valid_reg;
        out_ev_next     = out_ev_reg;
        out_bv_next     = out_bv_reg;
        out_bi_next     = out_bi_reg;

        // result taken downstream frees the register
        out_valid_next = out_valid_reg && out_stall;

        // shared unit defaults to the frame winner compare
        alu_req.op     = OP_CMP;
        alu_req.a      = lk_reg;
        alu_req.b      = frame_max_reg;
        alu_req.thr    = cfg.acc;
        alu_req.step   = cfg.step;
        alu_req.winner = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode)
                    begin
                        // clear item: confidences only, frame and held gesture kept
                        for (int i = 0; i < MAX_GESTURES; i++)
                        begin
                            conf_next[i] = '0;
                        end
                    end
                    else
                    begin
                        lk_next    = sat_one(likelihood);
                        state_next = S_LIKE;
                    end
                end
            end

            S_LIKE:
            begin
                if (alu_res.greater)
                begin
                    frame_max_next = lk_reg;
                    winner_next    = pos_reg;
                    found_next     = 1'b1;
                end
                if (last_item)
                begin
                    idx_next   = '0;
                    state_next = S_UPDATE;
                end
                else
                begin
                    pos_next   = pos_reg + IDX_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_UPDATE:
            begin
                // winner rises and is lifted to its likelihood, the rest decay
                alu_req.op     = OP_UPDATE;
                alu_req.a      = conf_reg[idx_reg];
                alu_req.winner = found_reg && (idx_reg == winner_reg);
                conf_next[idx_reg] = alu_res.value;
                if (last_idx)
                begin
                    idx_next        = '0;
                    cand_max_next   = '0;
                    cand_idx_next   = '0;
                    cand_found_next = 1'b0;
                    state_next      = S_CAND;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_CAND:
            begin
                // first strictly largest confidence above the hold level
                alu_req.a   = conf_reg[idx_reg];
                alu_req.b   = cand_max_reg;
                alu_req.thr = cfg.hold;
                if (alu_res.greater)
                begin
                    cand_max_next   = conf_reg[idx_reg];
                    cand_idx_next   = idx_reg;
                    cand_found_next = 1'b1;
                end
                if (last_idx)
                begin
                    idx_next   = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_DECIDE:
            begin
                // waits here until the result register has room
                if (!out_valid_reg || !out_stall)
                begin
                    out_ev_next = EV_SAME;
                    if (!held_valid_reg)
                    begin
                        if (cand_found_reg)
                        begin
                            held_valid_next = 1'b1;
                            held_idx_next   = cand_idx_reg;
                            out_ev_next     = EV_NEW;
                            // lock in: other active gestures start again from zero
                            for (int i = 0; i < MAX_GESTURES; i++)
                            begin
                                if ((CNT_W'(i) < cfg.count) && (IDX_W'(i) != cand_idx_reg))
                                begin
                                    conf_next[i] = '0;
                                end
                            end
                        end
                    end
                    else if (!cand_found_reg || (cand_idx_reg != held_idx_reg))
                    begin
                        held_valid_next = cand_found_reg;
                        held_idx_next   = cand_found_reg ? cand_idx_reg : '0;
                        out_ev_next     = EV_END;
                    end
                    out_bv_next    = held_valid_next;
                    out_bi_next    = held_valid_next ? held_idx_next : '0;
                    out_valid_next = 1'b1;

                    pos_next       = '0;
                    frame_max_next = '0;
                    winner_next    = '0;
                    found_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // nothing held always reports index zero
    a_idx_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !best_valid) |-> (best_index == '0))
        else $error("result with no held gesture carries a nonzero index");

    // a newly recognised gesture is always held
    a_new_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_NEW)) |-> best_valid)
        else $error("new gesture event without a held gesture");

    // a fresh result mirrors the held decision
    a_result_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (best_valid == held_valid_reg))
        else $error("result disagrees with held gesture state");

    // only defined event codes leave the block
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_res == EV_SAME) || (event_res == EV_NEW) ||
                       (event_res == EV_END)))
        else $error("undefined event code on result");
`endif

endmodule

FILE: test/gesture_decision_smoother_core_test.sv
// self-checking testbench of the gesture decision smoother core
module gesture_decision_smoother_core_test import gds_pkg::*;;

    // q1.10 unity and the limits of the run
    localparam int unsigned UNITY       = 1 << FRAC_BITS;
    // wait that covers the worst frame end at full count, with margin on top
    localparam int unsigned SETTLE      = 2 + 2 * MAX_GESTURES + 1 + 12;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 230;

    // opening frames at the reset settings (five gestures); a negative entry is a clear item
    int opening [22] = '{0, 2047, 1024, 2047, 819,   // saturation, tie on the saturated value
                         -1,                          // clear while a gesture is held
                         1025, 0, 0, 0, 820,          // held gesture moves to another index
                         0, 0, 0, 0, 0,               // decay only, same gesture
                         900, 10, -1, 5, 1000, 3};    // clear in the middle of a frame

    // one result item of the block
    typedef struct {
        ev_t              ev;
        logic             valid;
        logic [IDX_W-1:0] index;
    } decision_t;

    // scoreboard: own copy of the smoother state and the decisions still to come
    class decision_tracker;
        logic [CNT_W-1:0]  cfg_count = RST_COUNT;
        logic [CONF_W-1:0] cfg_step  = RST_STEP;
        logic [CONF_W-1:0] cfg_acc   = RST_ACC;
        logic [CONF_W-1:0] cfg_hold  = RST_HOLD;
        int unsigned conf [MAX_GESTURES];
        bit          held;
        int unsigned held_idx;
        int unsigned pos;
        int unsigned frame_peak;
        int unsigned frame_lead;
        bit          frame_won;
        decision_t   due_decisions [$];
        int unsigned mismatches;
        int unsigned frames;
        int unsigned clears;
        int unsigned writes;
        int unsigned ev_seen [3];

        function int unsigned clip(int unsigned v);
            return (v > UNITY) ? UNITY : v;
        endfunction

        function int unsigned active_count();
            if (cfg_count == 0) return 1;
            if (cfg_count > MAX_GESTURES) return MAX_GESTURES;
            return cfg_count;
        endfunction

        function int unsigned pending();
            return due_decisions.size();
        endfunction

        function void set_reg(reg_idx_t r, logic [DATA_W-1:0] v);
            writes++;
            case (r)
                REG_COUNT: cfg_count = v[CNT_W-1:0];
                REG_STEP:  cfg_step  = v[CONF_W-1:0];
                REG_ACC:   cfg_acc   = v[CONF_W-1:0];
                REG_HOLD:  cfg_hold  = v[CONF_W-1:0];
                default: ;
            endcase
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("mismatch: %s", what);
        endfunction

        // advance the state by one accepted item, queueing a decision at each frame end
        function void absorb_item(logic m, logic [CONF_W-1:0] lk);
            int unsigned n, stp, acc, hold, lkv, c, best, bidx, i;
            bit found;
            decision_t d;
            n    = active_count();
            stp  = clip(cfg_step);
            acc  = clip(cfg_acc);
            hold = clip(cfg_hold);
            if (m) begin
                for (i = 0; i < MAX_GESTURES; i++) conf[i] = 0;
                clears++;
                return;
            end
            lkv = clip(lk);
            if (lkv > frame_peak && lkv > acc) begin
                frame_peak = lkv;
                frame_lead = pos;
                frame_won  = 1'b1;
            end
            if (pos + 1 < n) begin
                pos++;
                return;
            end
            // frame end: winner rises, the rest decay
            for (i = 0; i < n; i++) begin
                c = conf[i];
                if (frame_won && i == frame_lead) begin
                    c += stp;
                    if (frame_peak > c) c = frame_peak;
                    c = clip(c);
                end else begin
                    c = (c > stp) ? c - stp : 0;
                end
                conf[i] = c;
            end
            best  = 0;
            bidx  = 0;
            found = 1'b0;
            for (i = 0; i < n; i++) begin
                if (conf[i] > best && conf[i] > hold) begin
                    best  = conf[i];
                    bidx  = i;
                    found = 1'b1;
                end
            end
            d.ev = EV_SAME;
            if (!held) begin
                if (found) begin
                    held     = 1'b1;
                    held_idx = bidx;
                    for (i = 0; i < n; i++) if (i != bidx) conf[i] = 0;
                    d.ev = EV_NEW;
                end
            end else if (!found || bidx != held_idx) begin
                held     = found;
                held_idx = found ? bidx : 0;
                d.ev     = EV_END;
            end
            pos        = 0;
            frame_peak = 0;
            frame_lead = 0;
            frame_won  = 1'b0;
            d.valid = held;
            d.index = held ? IDX_W'(held_idx) : '0;
            due_decisions.push_back(d);
            frames++;
        endfunction

        function void check_decision(logic [1:0] ev, logic bv, logic [IDX_W-1:0] bi);
            decision_t d;
            if (due_decisions.size() == 0) begin
                flag($sformatf("unexpected result: event_res %0d best_valid %0d best_index %0d",
                               ev, bv, bi));
                return;
            end
            d = due_decisions.pop_front();
            ev_seen[int'(d.ev)]++;
            if (ev !== d.ev)
                flag($sformatf("event_res expected %0d got %0d", d.ev, ev));
            if (bv !== d.valid)
                flag($sformatf("best_valid expected %0d got %0d", d.valid, bv));
            if (bi !== d.index)
                flag($sformatf("best_index expected %0d got %0d", d.index, bi));
        endfunction
    endclass

    // block signals, inputs at known values from time zero
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              mode       = 1'b0;
    logic [CONF_W-1:0] likelihood = '0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [1:0]        event_res;
    logic              best_valid;
    logic [IDX_W-1:0]  best_index;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    decision_tracker track;
    int unsigned     idle_pct  = 0;   // chance in a hundred that the sender idles a cycle
    int unsigned     stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int unsigned     quiet_cycles;
    int unsigned     fav       = 0;   // gesture that the current run of frames favours
    bit              quiet     = 1'b0;
    logic [CONF_W-1:0] fav_lk  = CONF_W'(UNITY);

    gesture_decision_smoother_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .likelihood (likelihood),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .best_valid (best_valid),
        .best_index (best_index),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 10 unit clock period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk)
    begin
        out_stall = (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // result monitor: values sampled at the rising edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            track.check_decision(event_res, best_valid, best_index);
    end

    // watchdog: any long stretch with no item moving on either channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles with no item accepted", quiet_cycles);
                $display("FAIL gesture_decision_smoother_core");
                $finish;
            end
        end
    end

    // offer one item, idling first at the current sender rate, and hold it until accepted
    task automatic send_item(logic m, logic [CONF_W-1:0] lk);
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        mode       = m;
        likelihood = lk;
        do @(posedge clk); while (in_stall);
        track.absorb_item(m, lk);
    endtask

    // sender stands back until every queued decision has come out
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (track.pending() != 0) @(posedge clk);
    endtask

    // two-phase register write: setup cycle, then access cycle
    task automatic write_reg(reg_idx_t r, logic [DATA_W-1:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({r, 2'b00});
        pwdata  = v;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        track.set_reg(r, v);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // settings only change with the block idle: results drained, then the frame-end latency
    task automatic apply_settings(logic [DATA_W-1:0] c, logic [DATA_W-1:0] s,
                                  logic [DATA_W-1:0] a, logic [DATA_W-1:0] h);
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_COUNT, c);
        write_reg(REG_STEP, s);
        write_reg(REG_ACC, a);
        write_reg(REG_HOLD, h);
    endtask

    // mostly well-formed frames around a favoured gesture, with noise, ties and clears
    task automatic play_gestures(int unsigned items);
        int unsigned k, n, lim, pick;
        logic m;
        logic [CONF_W-1:0] lk;
        for (k = 0; k < items; k++) begin
            n = track.active_count();
            // favourite switches now and then; some frames have no clear winner at all
            if (track.pos == 0) begin
                if (fav >= n || $urandom_range(0, 99) < 15) fav = $urandom_range(0, n - 1);
                quiet = ($urandom_range(0, 99) < 12);
            end
            lim  = track.clip(track.cfg_acc);
            pick = $urandom_range(0, 99);
            m    = 1'b0;
            if (pick < 3) begin
                m  = 1'b1;
                lk = CONF_W'($urandom_range(0, 2047));
            end else if (pick < 13) begin
                lk = CONF_W'($urandom_range(0, 2047));
            end else if (!quiet && track.pos == fav) begin
                lk     = CONF_W'($urandom_range(lim, UNITY));
                fav_lk = lk;
            end else if (pick < 20) begin
                // tie with the favourite: only the first of equals may win
                lk = fav_lk;
            end else begin
                lk = CONF_W'($urandom_range(0, (lim > 100) ? lim - 100 : lim));
            end
            send_item(m, lk);
        end
    endtask

    initial
    begin
        int unsigned p;
        logic [DATA_W-1:0] c, s, a, h;
        track = new();

        // reset held asserted at the start, released on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening at the reset settings
        foreach (opening[k]) begin
            if (opening[k] < 0) send_item(1'b1, CONF_W'(2047));
            else send_item(1'b0, CONF_W'(opening[k]));
        end
        // three items into a five-gesture frame, then the count drops to two:
        // the next item has passed the last position and closes the frame
        send_item(1'b0, CONF_W'(UNITY));
        send_item(1'b0, '0);
        send_item(1'b0, '0);
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        write_reg(REG_COUNT, 2);
        send_item(1'b0, '0);

        // random phases, each with its own settings and idling pattern
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin c = 5;  s = 102;  a = 819;  h = 512;  end
                // full count, largest step, zero thresholds
                1: begin c = 8;  s = 1024; a = 0;    h = 0;    end
                // count zero counts as one gesture, thresholds just under unity
                2: begin c = 0;  s = 1;    a = 1023; h = 1023; end
                // count and values beyond their ranges, clipped by the block
                3: begin c = 15; s = 2047; a = 2047; h = 2047; end
                default:
                begin
                    c = $urandom_range(1, 8);
                    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                    : $urandom_range(20, 300);
                    a = $urandom_range(400, 1000);
                    h = $urandom_range(100, 1000);
                end
            endcase
            apply_settings(c, s, a, h);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            play_gestures(PHASE_ITEMS / 2);
            // sender holds off once until the pipeline is empty
            if (p == 5) wait_for_results();
            play_gestures(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        // drain and give a late stray result time to show
        stall_pct = 0;
        wait_for_results();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d frames, %0d clear items and %0d register writes over %0d settings",
                 track.frames, track.clears, track.writes, PHASES + 1);
        $display("events: %0d same, %0d new, %0d ended; %0d mismatches",
                 track.ev_seen[EV_SAME], track.ev_seen[EV_NEW], track.ev_seen[EV_END],
                 track.mismatches);
        if (track.pending() != 0)
            $display("%0d expected results never arrived", track.pending());
        if (track.mismatches == 0 && track.pending() == 0)
            $display("PASS gesture_decision_smoother_core");
        else
            $display("FAIL gesture_decision_smoother_core");
        $finish;
    end

endmodule

FILE: sim.f
rtl/gds_pkg.sv
rtl/gds_cfg.sv
rtl/gds_alu.sv
rtl/gesture_decision_smoother_core.sv
test/gesture_decision_smoother_core_test.sv
